/* rtl/mppm_pkg.sv */
package mppm_pkg;

   localparam int MAX_NODES       = 65536;
   localparam int MAX_PATTERNS    = 1024;
   localparam int MAX_PATTERN_LEN = 128;

   localparam int NODE_W = $clog2(MAX_NODES);
   localparam int SYM_W  = 2;
   localparam int GOTO_W = NODE_W + SYM_W;
   localparam int PAT_W  = $clog2(MAX_PATTERNS);
   localparam int LEN_W  = 8;

   typedef enum logic [1:0] {
      CMD_PATTERN = 2'd0,
      CMD_BUILD   = 2'd1,
      CMD_TEXT    = 2'd2,
      CMD_QUERY   = 2'd3
   } cmd_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_A_ISS,
      ST_A_EVAL,
      ST_T_ISS,
      ST_T_EVAL,
      ST_T_CH_ISS,
      ST_T_CH_EVAL,
      ST_Q_ISS,
      ST_Q_LOAD,
      ST_Q_CH_ISS,
      ST_Q_CH_EVAL,
      ST_Q_DONE,
      ST_B0_ISS,
      ST_B0_PAR,
      ST_B0_EVAL,
      ST_B_POP,
      ST_B_NODE,
      ST_B_FAIL,
      ST_B_ISS,
      ST_B_CH,
      ST_B_EVAL
   } state_type;

endpackage

/* rtl/mppm_ram.sv */
module mppm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/multi_pattern_prefix_matcher_unit.sv */
// Aho-Corasick prefix matcher over a four-symbol alphabet (N, S, W, E).
// Input channel req_*: one command per transfer. tuser carries the command
// (pattern symbol, build links, text symbol, query), tlast marks the last
// symbol of a pattern being inserted. Result channel rsp_*: one transfer per
// query with the longest matched prefix length and the pattern id.
// One sequencer drives single-port-read RAMs (goto, failure, parent, seen,
// pattern records, breadth queue); every RAM read is issued in one state and
// evaluated in the next, and req_tready is high only while the sequencer idles.
// A pattern symbol reads one goto entry and may allocate a node; a text symbol
// steps the cursor and visits nodes on the failure chain (newly marked nodes
// and the marked node that stops it); a query climbs parents until a marked
// node or the root; a build links the root children and then expands each
// queued node.
// After reset a clearing pass zeroes goto, failure, parent and seen RAMs,
// one goto entry per cycle, with req_tready low.
// The answer waits in an output register; the block keeps accepting items
// while it waits, and only a second query stalls until rsp_tready takes it.
module multi_pattern_prefix_matcher_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // symbol[1:0], pattern_id[11:2], zero pad
   input  logic [1:0]  req_tuser,   // command[1:0]
   input  logic        req_tlast,   // last_symbol
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // prefix_length[7:0], result_pattern[17:8], pad
);

   localparam int NW = mppm_pkg::NODE_W;
   localparam int GW = mppm_pkg::GOTO_W;
   localparam int PW = mppm_pkg::PAT_W;
   localparam int LW = mppm_pkg::LEN_W;

   mppm_pkg::state_type state_ff, state_in;
   logic [GW-1:0] clr_ff, clr_in;
   mppm_pkg::cmd_type cmd_ff, cmd_in;
   logic [1:0]    sym_ff, sym_in;
   logic          last_ff, last_in;
   logic [PW-1:0] id_ff, id_in;
   logic [NW-1:0] cursor_ff, cursor_in;
   logic [LW-1:0] depth_ff, depth_in;
   logic [NW-1:0] count_ff, count_in;
   logic [NW-1:0] node_ff, node_in;     // walk pointer / node being expanded
   logic [NW-1:0] fnode_ff, fnode_in;   // failure of node being expanded
   logic [NW-1:0] child_ff, child_in;
   logic [1:0]    slot_ff, slot_in;
   logic [NW:0]   head_ff, head_in;
   logic [NW:0]   tail_ff, tail_in;
   logic [LW-1:0] ans_ff, ans_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [LW-1:0] rsp_len_ff, rsp_len_in;
   logic [PW-1:0] rsp_id_ff, rsp_id_in;

   // RAM ports
   logic          g_we, f_we, p_we, s_we, e_we, l_we, q_we;
   logic [GW-1:0] g_wa, g_ra;
   logic [NW-1:0] g_wd, g_rd;
   logic [NW-1:0] f_wa, f_ra, f_wd, f_rd;
   logic [NW-1:0] p_wa, p_ra, p_wd, p_rd;
   logic [NW-1:0] s_wa, s_ra;
   logic          s_wd, s_rd;
   logic [PW-1:0] e_wa, e_ra, l_wa, l_ra;
   logic [NW-1:0] e_wd, e_rd;
   logic [LW-1:0] l_wd, l_rd;
   logic [NW-1:0] q_wa, q_ra, q_wd, q_rd;

   // insertion step values
   logic [NW-1:0] new_node, add_cursor;
   logic [LW-1:0] add_depth;

   mppm_ram #(.WIDTH(NW), .DEPTH(mppm_pkg::MAX_NODES * 4)) u_goto (
      .clock(clock), .wr_en(g_we), .wr_addr(g_wa), .wr_data(g_wd),
      .rd_addr(g_ra), .rd_data(g_rd));
   mppm_ram #(.WIDTH(NW), .DEPTH(mppm_pkg::MAX_NODES)) u_fail (
      .clock(clock), .wr_en(f_we), .wr_addr(f_wa), .wr_data(f_wd),
      .rd_addr(f_ra), .rd_data(f_rd));
   mppm_ram #(.WIDTH(NW), .DEPTH(mppm_pkg::MAX_NODES)) u_parent (
      .clock(clock), .wr_en(p_we), .wr_addr(p_wa), .wr_data(p_wd),
      .rd_addr(p_ra), .rd_data(p_rd));
   mppm_ram #(.WIDTH(1), .DEPTH(mppm_pkg::MAX_NODES)) u_seen (
      .clock(clock), .wr_en(s_we), .wr_addr(s_wa), .wr_data(s_wd),
      .rd_addr(s_ra), .rd_data(s_rd));
   mppm_ram #(.WIDTH(NW), .DEPTH(mppm_pkg::MAX_PATTERNS)) u_pend (
      .clock(clock), .wr_en(e_we), .wr_addr(e_wa), .wr_data(e_wd),
      .rd_addr(e_ra), .rd_data(e_rd));
   mppm_ram #(.WIDTH(LW), .DEPTH(mppm_pkg::MAX_PATTERNS)) u_plen (
      .clock(clock), .wr_en(l_we), .wr_addr(l_wa), .wr_data(l_wd),
      .rd_addr(l_ra), .rd_data(l_rd));
   mppm_ram #(.WIDTH(NW), .DEPTH(mppm_pkg::MAX_NODES)) u_queue (
      .clock(clock), .wr_en(q_we), .wr_addr(q_wa), .wr_data(q_wd),
      .rd_addr(q_ra), .rd_data(q_rd));

   assign req_tready = (state_ff == mppm_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_id_ff, rsp_len_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mppm_pkg::ST_CLEAR;
         clr_ff       <= '0;
         cursor_ff    <= '0;
         depth_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cursor_ff    <= cursor_in;
         depth_ff     <= depth_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff     <= cmd_in;
      sym_ff     <= sym_in;
      last_ff    <= last_in;
      id_ff      <= id_in;
      node_ff    <= node_in;
      fnode_ff   <= fnode_in;
      child_ff   <= child_in;
      slot_ff    <= slot_in;
      head_ff    <= head_in;
      tail_ff    <= tail_in;
      ans_ff     <= ans_in;
      rsp_len_ff <= rsp_len_in;
      rsp_id_ff  <= rsp_id_in;
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cmd_in       = cmd_ff;
      sym_in       = sym_ff;
      last_in      = last_ff;
      id_in        = id_ff;
      cursor_in    = cursor_ff;
      depth_in     = depth_ff;
      count_in     = count_ff;
      node_in      = node_ff;
      fnode_in     = fnode_ff;
      child_in     = child_ff;
      slot_in      = slot_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      ans_in       = ans_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      g_we = 1'b0; g_wa = '0; g_wd = '0; g_ra = '0;
      f_we = 1'b0; f_wa = '0; f_wd = '0; f_ra = '0;
      p_we = 1'b0; p_wa = '0; p_wd = '0; p_ra = '0;
      s_we = 1'b0; s_wa = '0; s_wd = 1'b0; s_ra = '0;
      e_we = 1'b0; e_wa = '0; e_wd = '0; e_ra = '0;
      l_we = 1'b0; l_wa = '0; l_wd = '0; l_ra = '0;
      q_we = 1'b0; q_wa = '0; q_wd = '0; q_ra = '0;

      new_node   = count_ff + NW'(1);
      add_cursor = cursor_ff;
      add_depth  = depth_ff;

      unique case (state_ff)
         mppm_pkg::ST_CLEAR: begin
            g_we = 1'b1;
            g_wa = clr_ff;
            if (clr_ff[GW-1:NW] == '0) begin
               f_we = 1'b1; f_wa = clr_ff[NW-1:0];
               p_we = 1'b1; p_wa = clr_ff[NW-1:0];
               s_we = 1'b1; s_wa = clr_ff[NW-1:0];
            end
            clr_in = clr_ff + GW'(1);
            if (clr_ff == '1) begin
               state_in = mppm_pkg::ST_IDLE;
            end
         end
         mppm_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in  = mppm_pkg::cmd_type'(req_tuser);
               sym_in  = req_tdata[1:0];
               last_in = req_tlast;
               id_in   = req_tdata[PW+1:2];
               unique case (mppm_pkg::cmd_type'(req_tuser))
                  mppm_pkg::CMD_PATTERN: state_in = mppm_pkg::ST_A_ISS;
                  mppm_pkg::CMD_BUILD: begin
                     slot_in  = '0;
                     head_in  = '0;
                     tail_in  = '0;
                     state_in = mppm_pkg::ST_B0_ISS;
                  end
                  mppm_pkg::CMD_TEXT:  state_in = mppm_pkg::ST_T_ISS;
                  default:             state_in = mppm_pkg::ST_Q_ISS;
               endcase
            end
         end

         // pattern insertion
         mppm_pkg::ST_A_ISS: begin
            g_ra     = {cursor_ff, sym_ff};
            state_in = mppm_pkg::ST_A_EVAL;
         end
         mppm_pkg::ST_A_EVAL: begin
            if (g_rd != '0) begin
               add_cursor = g_rd;
            end else if (count_ff != NW'(mppm_pkg::MAX_NODES - 1)) begin
               // empty slot and room left: allocate a node
               count_in   = new_node;
               add_cursor = new_node;
               g_we = 1'b1; g_wa = {cursor_ff, sym_ff}; g_wd = new_node;
               p_we = 1'b1; p_wa = new_node; p_wd = cursor_ff;
               f_we = 1'b1; f_wa = new_node; f_wd = '0;
            end
            if (add_cursor != cursor_ff || g_rd != '0 ||
                count_ff != NW'(mppm_pkg::MAX_NODES - 1)) begin
               if (depth_ff < LW'(mppm_pkg::MAX_PATTERN_LEN)) begin
                  add_depth = depth_ff + LW'(1);
               end
            end
            cursor_in = add_cursor;
            depth_in  = add_depth;
            if (last_ff) begin
               e_we = 1'b1; e_wa = id_ff; e_wd = add_cursor;
               l_we = 1'b1; l_wa = id_ff; l_wd = add_depth;
               cursor_in = '0;
               depth_in  = '0;
            end
            state_in = mppm_pkg::ST_IDLE;
         end

         // text step and failure-chain marking
         mppm_pkg::ST_T_ISS: begin
            g_ra     = {cursor_ff, sym_ff};
            state_in = mppm_pkg::ST_T_EVAL;
         end
         mppm_pkg::ST_T_EVAL: begin
            cursor_in = g_rd;
            node_in   = g_rd;
            state_in  = (g_rd == '0) ? mppm_pkg::ST_IDLE : mppm_pkg::ST_T_CH_ISS;
         end
         mppm_pkg::ST_T_CH_ISS: begin
            s_ra     = node_ff;
            f_ra     = node_ff;
            state_in = mppm_pkg::ST_T_CH_EVAL;
         end
         mppm_pkg::ST_T_CH_EVAL: begin
            if (s_rd) begin
               state_in = mppm_pkg::ST_IDLE;
            end else begin
               s_we = 1'b1; s_wa = node_ff; s_wd = 1'b1;
               node_in  = f_rd;
               state_in = (f_rd == '0) ? mppm_pkg::ST_IDLE : mppm_pkg::ST_T_CH_ISS;
            end
         end

         // query: climb parents until a seen node
         mppm_pkg::ST_Q_ISS: begin
            e_ra     = id_ff;
            l_ra     = id_ff;
            state_in = mppm_pkg::ST_Q_LOAD;
         end
         mppm_pkg::ST_Q_LOAD: begin
            node_in  = e_rd;
            ans_in   = l_rd;
            state_in = mppm_pkg::ST_Q_CH_ISS;
         end
         mppm_pkg::ST_Q_CH_ISS: begin
            // parent ids are always lower, so the climb ends at the root
            if (node_ff == '0) begin
               ans_in   = '0;
               state_in = mppm_pkg::ST_Q_DONE;
            end else begin
               s_ra     = node_ff;
               p_ra     = node_ff;
               state_in = mppm_pkg::ST_Q_CH_EVAL;
            end
         end
         mppm_pkg::ST_Q_CH_EVAL: begin
            if (s_rd) begin
               state_in = mppm_pkg::ST_Q_DONE;
            end else begin
               if (ans_ff != '0) begin
                  ans_in = ans_ff - LW'(1);
               end
               node_in  = p_rd;
               state_in = mppm_pkg::ST_Q_CH_ISS;
            end
         end
         mppm_pkg::ST_Q_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_len_in   = ans_ff;
               rsp_id_in    = id_ff;
               state_in     = mppm_pkg::ST_IDLE;
            end
         end

         // build: root children
         mppm_pkg::ST_B0_ISS: begin
            g_ra     = {NW'(0), slot_ff};
            state_in = mppm_pkg::ST_B0_PAR;
         end
         mppm_pkg::ST_B0_PAR: begin
            child_in = g_rd;
            p_ra     = g_rd;
            state_in = mppm_pkg::ST_B0_EVAL;
         end
         mppm_pkg::ST_B0_EVAL: begin
            if (child_ff != '0 && p_rd == '0 && !tail_ff[NW]) begin
               f_we = 1'b1; f_wa = child_ff; f_wd = '0;
               q_we = 1'b1; q_wa = tail_ff[NW-1:0]; q_wd = child_ff;
               tail_in = tail_ff + (NW+1)'(1);
            end
            slot_in  = slot_ff + 2'd1;
            state_in = (slot_ff == 2'd3) ? mppm_pkg::ST_B_POP : mppm_pkg::ST_B0_ISS;
         end

         // build: breadth-first expansion
         mppm_pkg::ST_B_POP: begin
            if (head_ff == tail_ff) begin
               cursor_in = '0;
               depth_in  = '0;
               state_in  = mppm_pkg::ST_IDLE;
            end else begin
               q_ra     = head_ff[NW-1:0];
               head_in  = head_ff + (NW+1)'(1);
               state_in = mppm_pkg::ST_B_NODE;
            end
         end
         mppm_pkg::ST_B_NODE: begin
            node_in  = q_rd;
            f_ra     = q_rd;
            state_in = mppm_pkg::ST_B_FAIL;
         end
         mppm_pkg::ST_B_FAIL: begin
            fnode_in = f_rd;
            slot_in  = '0;
            state_in = mppm_pkg::ST_B_ISS;
         end
         mppm_pkg::ST_B_ISS: begin
            g_ra     = {node_ff, slot_ff};
            state_in = mppm_pkg::ST_B_CH;
         end
         mppm_pkg::ST_B_CH: begin
            child_in = g_rd;
            p_ra     = g_rd;
            g_ra     = {fnode_ff, slot_ff};
            state_in = mppm_pkg::ST_B_EVAL;
         end
         mppm_pkg::ST_B_EVAL: begin
            if (child_ff != '0 && p_rd == node_ff) begin
               f_we = 1'b1; f_wa = child_ff; f_wd = g_rd;
               if (!tail_ff[NW]) begin
                  q_we = 1'b1; q_wa = tail_ff[NW-1:0]; q_wd = child_ff;
                  tail_in = tail_ff + (NW+1)'(1);
               end
            end else begin
               g_we = 1'b1; g_wa = {node_ff, slot_ff}; g_wd = g_rd;
            end
            slot_in  = slot_ff + 2'd1;
            state_in = (slot_ff == 2'd3) ? mppm_pkg::ST_B_POP : mppm_pkg::ST_B_ISS;
         end
         default: begin
            state_in = mppm_pkg::ST_IDLE;
         end
      endcase
   end

`ifndef SYNTH
   // no item may enter while the RAMs are still being cleared
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mppm_pkg::ST_CLEAR) |-> !req_tready)
      else $error("item accepted during clearing pass");

   // finishing a build returns the cursor to the root
   a_build_rewinds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mppm_pkg::ST_B_POP && head_ff == tail_ff) |=> (cursor_ff == '0))
      else $error("cursor not at root after build");

   // insertion depth saturates
   a_depth_sat: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= LW'(mppm_pkg::MAX_PATTERN_LEN))
      else $error("insert depth above limit");

   // a new answer never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(rsp_id_ff)))
      else $error("pending answer overwritten");
`endif

endmodule
